>>> rtl/core/first_fit_segment_allocator_assert.svh
// Assertion macros for the segment allocator.
// Both sample on the rising edge of clk and are disabled while arst_n is low.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define FFSA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define FFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FFSA_ASSERT(lbl, prop, msg)
`define FFSA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/ffsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffsa_pkg;

	localparam int DEF_MAX_SEGMENTS = 16;
	localparam int DEF_ADDR_BITS    = 32;

	localparam int SIZE_W  = 32;
	localparam int OWNER_W = 16;
	localparam int PRIO_W  = 8;
	localparam int STAT_W  = 2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_FIT     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_TABLE_FULL = 2'd3;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic clr;
		logic ins;
		logic del;
	} ffsa_cmd_t;

	// per-cell report back to the sequencer
	typedef struct packed {
		logic live;
		logic hit;
		logic fail;
	} ffsa_rpt_t;

endpackage

`default_nettype wire

>>> rtl/core/ffsa_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ffsa_cell #(
	parameter int EW = 33
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ffsa_pkg::ffsa_cmd_t            cmd,
	input  logic                           occ,
	input  logic                           op_free,
	input  logic [ffsa_pkg::SIZE_W-1:0]    req,
	input  logic [ffsa_pkg::OWNER_W-1:0]   key,
	input  logic [EW-1:0]                  lim,
	input  logic [EW-1:0]                  new_start,
	input  logic [EW-1:0]                  new_end,
	input  logic [ffsa_pkg::OWNER_W-1:0]   new_owner,
	input  logic [ffsa_pkg::PRIO_W-1:0]    new_prio,
	input  logic                           tok_in,
	input  logic [EW-1:0]                  pend_in,
	output logic                           tok_out,
	output logic [EW-1:0]                  pend_out,
	input  logic [EW-1:0]                  l_start,
	input  logic [EW-1:0]                  l_end,
	input  logic [ffsa_pkg::OWNER_W-1:0]   l_owner,
	input  logic [ffsa_pkg::PRIO_W-1:0]    l_prio,
	input  logic [EW-1:0]                  r_start,
	input  logic [EW-1:0]                  r_end,
	input  logic [ffsa_pkg::OWNER_W-1:0]   r_owner,
	input  logic [ffsa_pkg::PRIO_W-1:0]    r_prio,
	output logic [EW-1:0]                  seg_start,
	output logic [EW-1:0]                  seg_end,
	output logic [ffsa_pkg::OWNER_W-1:0]   seg_owner,
	output logic [ffsa_pkg::PRIO_W-1:0]    seg_prio,
	output ffsa_pkg::ffsa_rpt_t            rpt,
	output logic [EW-1:0]                  hit_addr
);
	import ffsa_pkg::*;

	logic                tok_q;
	logic [EW-1:0]       pend_q;
	logic                passed_q;
	logic                hit_q;
	logic [EW-1:0]       start_q;
	logic [EW-1:0]       end_q;
	logic [OWNER_W-1:0]  owner_q;
	logic [PRIO_W-1:0]   prio_q;

	logic [EW-1:0]       bound;
	logic [EW-1:0]       gap;
	logic                fit;
	logic                match;
	logic                hit;
	logic                fail;
	logic                pass;

	// an empty cell stands for the tail gap up to the memory limit
	assign bound = occ ? start_q : lim;
	assign gap   = (bound > pend_q) ? bound - pend_q : '0;
	assign fit   = 33'(gap) >= {1'b0, req};
	assign match = occ && (owner_q == key);

	always_comb begin
		if (op_free) begin
			hit  = tok_q && match;
			fail = tok_q && !occ;
			pass = tok_q && occ && !match;
		end else begin
			hit  = tok_q && fit;
			fail = tok_q && !occ && !fit;
			pass = tok_q && occ && !fit;
		end
	end

	assign tok_out  = pass;
	assign pend_out = end_q;
	assign hit_addr = hit ? pend_q : '0;
	assign rpt      = '{live: tok_q, hit: hit, fail: fail};

	assign seg_start = start_q;
	assign seg_end   = end_q;
	assign seg_owner = owner_q;
	assign seg_prio  = prio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q    <= 1'b0;
			passed_q <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (cmd.clr) begin
				passed_q <= 1'b0;
				hit_q    <= 1'b0;
			end else begin
				if (pass)
					passed_q <= 1'b1;
				if (hit)
					hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_in;
		if (cmd.ins) begin
			if (hit_q) begin
				start_q <= new_start;
				end_q   <= new_end;
				owner_q <= new_owner;
				prio_q  <= new_prio;
			end else if (!passed_q) begin
				// open the slot: take the entry from the left
				start_q <= l_start;
				end_q   <= l_end;
				owner_q <= l_owner;
				prio_q  <= l_prio;
			end
		end else if (cmd.del) begin
			if (!passed_q) begin
				// close the slot: take the entry from the right
				start_q <= r_start;
				end_q   <= r_end;
				owner_q <= r_owner;
				prio_q  <= r_prio;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/first_fit_segment_allocator.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-----------------------------------------------
// input    | in_valid / in_stall       | opcode, request_size, owner_id, priority_req
// result   | out_valid / out_stall     | status, start_address
// config   | cfg_valid / cfg_ready     | memory_size
//
// A search token walks the chain of segment cells, one cell per cycle. An item
// that finds its gap or owner goes through the shift state to the result state,
// a search that runs out goes straight to the result state, and a full table or a
// zero-size allocate skips the scan. The next item can be accepted in the cycle
// after its result is loaded. The table shifts in the cycle after a hit.
// cfg_ready is always high. arst_n empties the table and sets memory_size to zero.
// A stalled result holds in the output register while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none

`include "first_fit_segment_allocator_assert.svh"

module first_fit_segment_allocator #(
	parameter int MAX_SEGMENTS = ffsa_pkg::DEF_MAX_SEGMENTS,
	parameter int ADDR_BITS    = ffsa_pkg::DEF_ADDR_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ffsa_pkg::SIZE_W-1:0]     memory_size,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic [ffsa_pkg::SIZE_W-1:0]     request_size,
	input  logic [ffsa_pkg::OWNER_W-1:0]    owner_id,
	input  logic [ffsa_pkg::PRIO_W-1:0]     priority_req,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ffsa_pkg::STAT_W-1:0]     status,
	output logic [ffsa_pkg::SIZE_W-1:0]     start_address
);
	import ffsa_pkg::*;

	localparam int AB = (ADDR_BITS < SIZE_W) ? ADDR_BITS : SIZE_W;
	localparam int EW = AB + 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [SIZE_W:0] CAP = (SIZE_W + 1)'(1) << AB;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0]          state_q;
	logic [SIZE_W-1:0]   mem_size_q;
	logic [EW-1:0]       lim_q;
	logic [SIZE_W:0]     lim_full;
	logic                op_q;
	logic [SIZE_W-1:0]   req_q;
	logic [OWNER_W-1:0]  own_q;
	logic [PRIO_W-1:0]   prio_q;
	logic [CW-1:0]       count_q;
	logic [EW-1:0]       addr_q;
	logic [STAT_W-1:0]   res_status_q;
	logic [SIZE_W-1:0]   res_addr_q;
	logic                out_valid_q;
	logic [STAT_W-1:0]   status_q;
	logic [SIZE_W-1:0]   start_address_q;

	logic                accept;
	logic                full;
	logic                early;
	logic                load_out;
	ffsa_cmd_t           cmd;
	logic [EW-1:0]       new_end;

	logic                tok_chain  [MAX_SEGMENTS+1];
	logic [EW-1:0]       pend_chain [MAX_SEGMENTS+1];
	logic [EW-1:0]       c_start    [MAX_SEGMENTS];
	logic [EW-1:0]       c_end      [MAX_SEGMENTS];
	logic [OWNER_W-1:0]  c_owner    [MAX_SEGMENTS];
	logic [PRIO_W-1:0]   c_prio     [MAX_SEGMENTS];
	ffsa_rpt_t           c_rpt      [MAX_SEGMENTS];
	logic [EW-1:0]       c_hit_addr [MAX_SEGMENTS];

	logic [MAX_SEGMENTS-1:0] hit_vec;
	logic [MAX_SEGMENTS-1:0] fail_vec;
	logic [MAX_SEGMENTS-1:0] tok_vec;
	logic [EW-1:0]           hit_addr;
	logic                    any_hit;
	logic                    any_fail;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign full      = (count_q == CW'(MAX_SEGMENTS));
	assign early     = (op_q == OP_ALLOC) && (full || (req_q == '0));
	assign load_out  = (state_q == S_RESP) && (!out_valid_q || !out_stall);

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign start_address = start_address_q;

	// clamp the memory size to the address space
	assign lim_full = ({1'b0, mem_size_q} < CAP) ? {1'b0, mem_size_q} : CAP;
	assign new_end  = addr_q + EW'(req_q);

	always_comb begin
		cmd.clr = (state_q == S_START);
		cmd.ins = (state_q == S_SHIFT) && (op_q == OP_ALLOC);
		cmd.del = (state_q == S_SHIFT) && (op_q == OP_FREE);
	end

	assign tok_chain[0]  = (state_q == S_START) && !early;
	assign pend_chain[0] = '0;

	genvar k;
	generate
		for (k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
			logic [EW-1:0]      l_start;
			logic [EW-1:0]      l_end;
			logic [OWNER_W-1:0] l_owner;
			logic [PRIO_W-1:0]  l_prio;
			logic [EW-1:0]      r_start;
			logic [EW-1:0]      r_end;
			logic [OWNER_W-1:0] r_owner;
			logic [PRIO_W-1:0]  r_prio;
			logic               occ;

			assign occ = (count_q > CW'(k));

			if (k == 0) begin : g_first
				assign l_start = '0;
				assign l_end   = '0;
				assign l_owner = '0;
				assign l_prio  = '0;
			end else begin : g_mid
				assign l_start = c_start[k-1];
				assign l_end   = c_end[k-1];
				assign l_owner = c_owner[k-1];
				assign l_prio  = c_prio[k-1];
			end

			if (k == MAX_SEGMENTS - 1) begin : g_last
				assign r_start = c_start[k];
				assign r_end   = c_end[k];
				assign r_owner = c_owner[k];
				assign r_prio  = c_prio[k];
			end else begin : g_inner
				assign r_start = c_start[k+1];
				assign r_end   = c_end[k+1];
				assign r_owner = c_owner[k+1];
				assign r_prio  = c_prio[k+1];
			end

			ffsa_cell #(
				.EW(EW)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.occ       (occ),
				.op_free   (op_q),
				.req       (req_q),
				.key       (own_q),
				.lim       (lim_q),
				.new_start (addr_q),
				.new_end   (new_end),
				.new_owner (own_q),
				.new_prio  (prio_q),
				.tok_in    (tok_chain[k]),
				.pend_in   (pend_chain[k]),
				.tok_out   (tok_chain[k+1]),
				.pend_out  (pend_chain[k+1]),
				.l_start   (l_start),
				.l_end     (l_end),
				.l_owner   (l_owner),
				.l_prio    (l_prio),
				.r_start   (r_start),
				.r_end     (r_end),
				.r_owner   (r_owner),
				.r_prio    (r_prio),
				.seg_start (c_start[k]),
				.seg_end   (c_end[k]),
				.seg_owner (c_owner[k]),
				.seg_prio  (c_prio[k]),
				.rpt       (c_rpt[k]),
				.hit_addr  (c_hit_addr[k])
			);

			assign hit_vec[k]  = c_rpt[k].hit;
			assign fail_vec[k] = c_rpt[k].fail;
			assign tok_vec[k]  = c_rpt[k].live;
		end
	endgenerate

	always_comb begin
		hit_addr = '0;
		for (int i = 0; i < MAX_SEGMENTS; i++)
			hit_addr = hit_addr | c_hit_addr[i];
	end

	assign any_hit  = |hit_vec;
	// a token leaving the last cell found nothing
	assign any_fail = (|fail_vec) || tok_chain[MAX_SEGMENTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q <= '0;
			lim_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				mem_size_q <= memory_size;
			lim_q <= EW'(lim_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			req_q  <= request_size;
			own_q  <= owner_id;
			prio_q <= priority_req;
		end
		if (state_q == S_SCAN && any_hit)
			addr_q <= hit_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			count_q         <= '0;
			res_status_q    <= STAT_OK;
			res_addr_q      <= '0;
			out_valid_q     <= 1'b0;
			status_q        <= STAT_OK;
			start_address_q <= '0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_START;
				end
				S_START: begin
					res_addr_q <= '0;
					if (op_q == OP_ALLOC && full) begin
						res_status_q <= STAT_TABLE_FULL;
						state_q      <= S_RESP;
					end else if (op_q == OP_ALLOC && req_q == '0) begin
						res_status_q <= STAT_NO_FIT;
						state_q      <= S_RESP;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (any_hit) begin
						state_q <= S_SHIFT;
					end else if (any_fail) begin
						res_status_q <= (op_q == OP_FREE) ? STAT_NOT_FOUND : STAT_NO_FIT;
						state_q      <= S_RESP;
					end
				end
				S_SHIFT: begin
					res_status_q <= STAT_OK;
					if (op_q == OP_ALLOC) begin
						count_q    <= count_q + CW'(1);
						res_addr_q <= SIZE_W'(addr_q);
					end else begin
						count_q    <= count_q - CW'(1);
						res_addr_q <= '0;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					// hold until the output register is free
					if (load_out) begin
						status_q        <= res_status_q;
						start_address_q <= res_addr_q;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`FFSA_ASSERT(a_count_range, count_q <= CW'(MAX_SEGMENTS), "segment count beyond capacity")
	`FFSA_ASSERT(a_one_hit, $onehot0(hit_vec), "more than one cell hit")
	`FFSA_ASSERT(a_one_token, $onehot0(tok_vec), "more than one search token")
	`FFSA_ASSERT(a_token_scan, (tok_vec == '0) || (state_q == S_SCAN), "token outside scan")
	`FFSA_ASSERT_NEXT(a_ins_count, cmd.ins, count_q == $past(count_q) + CW'(1), "insert lost")

endmodule

`default_nettype wire

>>> verif/segment_alloc_checker.sv
`timescale 1ns / 1ps

module segment_alloc_checker #(
	parameter int MAX_SEGMENTS = ffsa_pkg::DEF_MAX_SEGMENTS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [ffsa_pkg::SIZE_W-1:0]     memory_size,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic                            opcode,
	input  logic [ffsa_pkg::SIZE_W-1:0]     request_size,
	input  logic [ffsa_pkg::OWNER_W-1:0]    owner_id,
	input  logic [ffsa_pkg::PRIO_W-1:0]     priority_req,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [ffsa_pkg::STAT_W-1:0]     status,
	input  logic [ffsa_pkg::SIZE_W-1:0]     start_address,
	output int                              fails,
	output int                              replies_due
);

	typedef struct packed {
		logic [ffsa_pkg::STAT_W-1:0] status;
		logic [ffsa_pkg::SIZE_W-1:0] start;
	} reply_t;

	logic [ffsa_pkg::SIZE_W-1:0]  mem_units = '0;
	logic [ffsa_pkg::SIZE_W-1:0]  seg_base [MAX_SEGMENTS];
	logic [ffsa_pkg::SIZE_W-1:0]  seg_len  [MAX_SEGMENTS];
	logic [ffsa_pkg::OWNER_W-1:0] seg_tag  [MAX_SEGMENTS];
	logic [ffsa_pkg::PRIO_W-1:0]  seg_pri  [MAX_SEGMENTS];
	int                           seg_used;
	reply_t                       replies_pending [$];

	// first-fit placement or owner release; updates the table copy
	task automatic predict_reply(input logic op, input logic [ffsa_pkg::SIZE_W-1:0] req,
			input logic [ffsa_pkg::OWNER_W-1:0] owner,
			input logic [ffsa_pkg::PRIO_W-1:0] prio, output reply_t rep);
		logic [63:0] seg_end;
		logic [63:0] gap_end;
		logic [63:0] at;
		logic [63:0] need;
		bit          placed;
		int          pos;
		int          i;
		int          k;
		rep.status = ffsa_pkg::STAT_OK;
		rep.start = '0;
		placed = 1'b0;
		pos = 0;
		at = '0;
		need = {32'd0, req};
		if (op == ffsa_pkg::OP_ALLOC) begin
			if (seg_used >= MAX_SEGMENTS) begin
				rep.status = ffsa_pkg::STAT_TABLE_FULL;
			end else if (req == '0) begin
				rep.status = ffsa_pkg::STAT_NO_FIT;
			end else begin
				// front gap runs to the first segment, or to the end of memory
				gap_end = (seg_used == 0) ? {32'd0, mem_units} : {32'd0, seg_base[0]};
				if (gap_end >= need)
					placed = 1'b1;
				for (i = 0; i < seg_used && !placed; i++) begin
					seg_end = {32'd0, seg_base[i]} + {32'd0, seg_len[i]};
					gap_end = (i + 1 < seg_used) ? {32'd0, seg_base[i+1]} : {32'd0, mem_units};
					if (gap_end > seg_end && gap_end - seg_end >= need) begin
						placed = 1'b1;
						pos = i + 1;
						at = seg_end;
					end
				end
				if (placed) begin
					for (k = seg_used; k > pos; k--) begin
						seg_base[k] = seg_base[k-1];
						seg_len[k]  = seg_len[k-1];
						seg_tag[k]  = seg_tag[k-1];
						seg_pri[k]  = seg_pri[k-1];
					end
					seg_base[pos] = at[31:0];
					seg_len[pos]  = req;
					seg_tag[pos]  = owner;
					seg_pri[pos]  = prio;
					seg_used++;
					rep.start = at[31:0];
				end else begin
					rep.status = ffsa_pkg::STAT_NO_FIT;
				end
			end
		end else begin
			pos = -1;
			for (i = 0; i < seg_used && pos < 0; i++)
				if (seg_tag[i] == owner)
					pos = i;
			if (pos < 0) begin
				rep.status = ffsa_pkg::STAT_NOT_FOUND;
			end else begin
				for (k = pos; k + 1 < seg_used; k++) begin
					seg_base[k] = seg_base[k+1];
					seg_len[k]  = seg_len[k+1];
					seg_tag[k]  = seg_tag[k+1];
					seg_pri[k]  = seg_pri[k+1];
				end
				seg_used--;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			seg_used = 0;
			mem_units = '0;
			replies_pending.delete();
			replies_due <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (replies_pending.size() == 0) begin
					$error("result with nothing expected: status %0d, start_address %0d",
						status, start_address);
					fails++;
				end else begin
					want = replies_pending.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fails++;
					end
					if (start_address !== want.start) begin
						$error("start_address: expected %0d, got %0d", want.start,
							start_address);
						fails++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				mem_units = memory_size;
			if (in_valid && !in_stall) begin
				predict_reply(opcode, request_size, owner_id, priority_req, want);
				// queue the expected reply at the tail
				replies_pending = {replies_pending, want};
			end
			replies_due <= replies_pending.size();
		end
	end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int QUIET_LIMIT = 5000;
	localparam int BLOCK_ITEMS = 108;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [ffsa_pkg::SIZE_W-1:0]     memory_size = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic                            opcode = ffsa_pkg::OP_ALLOC;
	logic [ffsa_pkg::SIZE_W-1:0]     request_size = '0;
	logic [ffsa_pkg::OWNER_W-1:0]    owner_id = '0;
	logic [ffsa_pkg::PRIO_W-1:0]     priority_req = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [ffsa_pkg::STAT_W-1:0]     status;
	logic [ffsa_pkg::SIZE_W-1:0]     start_address;

	int                              fails;
	int                              replies_due;
	int                              quiet;
	int                              sender_gap_pct = 19;
	int                              receiver_stall_pct = 64;
	logic [ffsa_pkg::SIZE_W-1:0]     cur_units = '0;

	always #4 clk = ~clk;

	first_fit_segment_allocator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.memory_size  (memory_size),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.request_size (request_size),
		.owner_id     (owner_id),
		.priority_req (priority_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.start_address(start_address)
	);

	segment_alloc_checker i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.memory_size  (memory_size),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.request_size (request_size),
		.owner_id     (owner_id),
		.priority_req (priority_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.start_address(start_address),
		.fails        (fails),
		.replies_due  (replies_due)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// end the run when no channel has moved for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send_request(input logic op, input logic [ffsa_pkg::SIZE_W-1:0] req,
			input logic [ffsa_pkg::OWNER_W-1:0] owner, input logic [ffsa_pkg::PRIO_W-1:0] prio);
		int gap;
		gap = ($urandom_range(99) < sender_gap_pct) ? $urandom_range(6, 1) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		request_size <= req;
		owner_id     <= owner;
		priority_req <= prio;
		do @(posedge clk); while (in_stall);
	endtask

	// hold the sender until every result is back, then let the table shift settle
	task automatic drain_replies();
		in_valid <= 1'b0;
		@(posedge clk);
		while (replies_due != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_memory_size(input logic [ffsa_pkg::SIZE_W-1:0] units);
		cfg_valid   <= 1'b1;
		memory_size <= units;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_units = units;
	endtask

	function automatic logic [ffsa_pkg::SIZE_W-1:0] pick_size(
			input logic [ffsa_pkg::SIZE_W-1:0] units);
		int                          r;
		logic [ffsa_pkg::SIZE_W-1:0] cap;
		r = $urandom_range(99);
		cap = units >> 2;
		if (cap == '0)
			cap = 1;
		if (r < 3)
			return '0;
		else if (r < 8)
			return $urandom;
		else if (r < 12)
			return units;
		return $urandom_range(cap, 1);
	endfunction

	function automatic logic [ffsa_pkg::OWNER_W-1:0] pick_owner();
		logic [31:0] wide;
		// keep most owners in a small pool so frees find something
		wide = ($urandom_range(99) < 85) ? $urandom_range(11) : $urandom;
		return wide[ffsa_pkg::OWNER_W-1:0];
	endfunction

	initial begin
		logic [ffsa_pkg::SIZE_W-1:0] block_units [12];
		logic [31:0]                 pri;
		int                          mode;
		int                          blk;
		int                          n;
		int                          k;
		block_units = '{32'hFFFF_FFFF, 32'd256, 32'd64, 32'd0, 32'd1000, 32'h8000_0000,
			32'd128, 32'd16, 32'd4096, 32'hFFFF_FFFF, 32'd300, 32'd0};
		block_units[11] = $urandom;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty table, memory still at its reset size of zero
		send_request(ffsa_pkg::OP_FREE, 32'hFFFF_FFFF, 16'h0005, 8'hFF);
		send_request(ffsa_pkg::OP_ALLOC, 32'd1, 16'h0001, 8'h00);
		drain_replies();
		write_memory_size(32'd100);
		send_request(ffsa_pkg::OP_ALLOC, 32'd0, 16'h0002, 8'h55);
		send_request(ffsa_pkg::OP_ALLOC, 32'd101, 16'h0002, 8'hAA);
		send_request(ffsa_pkg::OP_ALLOC, 32'd100, 16'hFFFF, 8'hFF);
		send_request(ffsa_pkg::OP_FREE, 32'd0, 16'hFFFF, 8'h00);
		for (k = 0; k < 16; k++)
			send_request(ffsa_pkg::OP_ALLOC, 32'd5, 16'(k), 8'(k));
		send_request(ffsa_pkg::OP_ALLOC, 32'd1, 16'h00AA, 8'h00);
		// open a hole in the middle and refill it
		send_request(ffsa_pkg::OP_FREE, 32'd0, 16'h0003, 8'h00);
		send_request(ffsa_pkg::OP_ALLOC, 32'd5, 16'h0100, 8'h80);
		drain_replies();
		// shrink memory below the end of the last segment
		write_memory_size(32'd20);
		send_request(ffsa_pkg::OP_FREE, 32'd0, 16'h000F, 8'h00);
		send_request(ffsa_pkg::OP_ALLOC, 32'd1, 16'h8000, 8'h01);

		for (mode = 0; mode < 3; mode++) begin
			for (blk = 0; blk < 4; blk++) begin
				drain_replies();
				if (mode == 1) begin
					sender_gap_pct = 64;
					receiver_stall_pct = 19;
				end else if (mode == 2) begin
					sender_gap_pct = 0;
					receiver_stall_pct = 0;
				end
				write_memory_size(block_units[mode*4 + blk]);
				for (n = 0; n < BLOCK_ITEMS; n++) begin
					pri = $urandom;
					if ($urandom_range(99) < 55)
						send_request(ffsa_pkg::OP_ALLOC, pick_size(cur_units), pick_owner(),
							pri[7:0]);
					else
						send_request(ffsa_pkg::OP_FREE, $urandom, pick_owner(), pri[7:0]);
				end
			end
		end

		drain_replies();
		repeat (24) @(posedge clk);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> first_fit_segment_allocator.f
+incdir+rtl/core
rtl/core/ffsa_pkg.sv
rtl/core/ffsa_cell.sv
rtl/core/first_fit_segment_allocator.sv
verif/segment_alloc_checker.sv
verif/testbench.sv
